@@ design/plc_pkg.sv @@
// ---------------------------------------------------------------------------
// plc_pkg: shared types and constants for the piecewise-linear calibration
// Table geometry, field widths, the table write request and the sequencer
// states used by the calibration block and its breakpoint table.
// ---------------------------------------------------------------------------
package plc_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Field widths.
    localparam int X_W   = 12;
    localparam int Y_W   = 16;
    localparam int SEG_W = 4;

    // Width that holds a request index, a table index and the table size,
    // so the bounds check on a write compares against the full entry count.
    localparam int IDX_WIDE_W = ((IDX_W > SEG_W) ? IDX_W : SEG_W) + 1;

    // Product of an x difference and a y difference, and the signed sum
    // of y0 with the quotient.
    localparam int PROD_W = X_W + Y_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CNT_W  = $clog2(PROD_W);

    // Stream packing.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    typedef logic [X_W-1:0]   x_t;
    typedef logic [Y_W-1:0]   y_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam x_t X_MAX = {X_W{1'b1}};

    // Input kinds carried in tuser.
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    // One breakpoint of the table.
    typedef struct packed {
        x_t x;
        y_t y;
    } plc_entry_t;

    // Write request into the table.
    typedef struct packed {
        logic en;
        idx_t idx;
        x_t   x;
        y_t   y;
    } plc_wr_t;

    // Conversion sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } plc_state_t;

endpackage

@@ design/piecewise_linear_calibration.sv @@
// ---------------------------------------------------------------------------
// piecewise_linear_calibration: sensor reading to level by table lookup
// Searches a breakpoint table and interpolates between two breakpoints with
// a bit-serial multiplier and a bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ channel. s_tuser selects a table write (0) or a
// conversion (1). A write stores one breakpoint in the accept cycle and gives
// no result; the block is ready again in the next cycle. A conversion reads
// the table one entry per cycle through its registered port until the first
// entry from 1 up whose x is at least the reading. After a match the block
// multiplies (one bit of |reading - x0| per cycle), divides (one quotient
// bit per cycle), then saturates the sum and registers the result. A flat
// segment skips multiply and divide, and an unmatched reading goes to the
// result after the last entry. One conversion is in flight at a time.
// The result waits in an output register on the m_ channel; while it waits
// the block keeps taking requests, and a finished conversion holds in its
// last state until the output register is free.
// Reset clears the sequencer, the output valid and the table valid bits, so
// the table reads as x = 0 at entry zero, full scale elsewhere, y = 0.
// ---------------------------------------------------------------------------
module piecewise_linear_calibration import plc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Request channel.
    input  logic                s_tvalid,
    output logic                s_tready,
    // entry_index[3:0], entry_x[15:4], entry_y[31:16], reading[43:32], zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                s_tuser,
    // Result channel.
    output logic                m_tvalid,
    input  logic                m_tready,
    // level[15:0], segment[19:16], zero
    output logic [M_DATA_W-1:0] m_tdata,
    // matched[0]
    output logic                m_tuser
);

    localparam idx_t LAST_IDX = idx_t'(TABLE_ENTRIES - 1);

    // Request fields.
    logic [SEG_W-1:0]      in_index;
    x_t                    in_x;
    y_t                    in_y;
    x_t                    in_reading;
    logic [IDX_WIDE_W-1:0] in_index_wide;
    logic                  s_accept;
    logic                  wr_ok;

    assign in_index      = s_tdata[3:0];
    assign in_x          = s_tdata[15:4];
    assign in_y          = s_tdata[31:16];
    assign in_reading    = s_tdata[43:32];
    assign in_index_wide = IDX_WIDE_W'(in_index);
    assign wr_ok         = in_index_wide < IDX_WIDE_W'(TABLE_ENTRIES);
    assign s_accept      = s_tvalid && s_tready;

    // Table.
    plc_wr_t    tbl_wr;
    idx_t       rd_addr;
    plc_entry_t rd_entry;

    assign tbl_wr.en  = s_accept && (s_tuser == KIND_WRITE) && wr_ok;
    assign tbl_wr.idx = idx_t'(in_index_wide);
    assign tbl_wr.x   = in_x;
    assign tbl_wr.y   = in_y;

    plc_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Sequencer and datapath registers.
    plc_state_t        state_reg,    state_next;
    idx_t              scan_idx_reg, scan_idx_next;
    x_t                reading_reg,  reading_next;
    x_t                x0_reg,       x0_next;
    y_t                y0_reg,       y0_next;
    logic              hit_reg,      hit_next;
    idx_t              seg_reg,      seg_next;
    logic [PROD_W-1:0] mcand_reg,    mcand_next;
    x_t                mplier_reg,   mplier_next;
    logic [PROD_W-1:0] acc_reg,      acc_next;
    x_t                rem_reg,      rem_next;
    x_t                dvs_reg,      dvs_next;
    logic              neg_reg,      neg_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;

    // Output register.
    logic              m_valid_reg,   m_valid_next;
    y_t                m_level_reg,   m_level_next;
    logic [SEG_W-1:0]  m_seg_reg,     m_seg_next;
    logic              m_matched_reg, m_matched_next;

    // Segment differences, taken when the scan hits.
    logic [X_W:0]      dx;
    logic [Y_W:0]      dy;
    logic [X_W:0]      den;
    x_t                dx_mag;
    y_t                dy_mag;
    x_t                den_mag;

    // Divider step.
    logic [X_W:0]      div_shift;
    logic [X_W:0]      div_trial;
    logic              div_ge;

    // Final sum and saturation.
    logic [SUM_W-1:0]  y0_ext;
    logic [SUM_W-1:0]  q_ext;
    logic [SUM_W-1:0]  sum;
    y_t                level_sat;
    logic              out_free;

    assign dx      = {1'b0, reading_reg} - {1'b0, x0_reg};
    assign dy      = {1'b0, rd_entry.y} - {1'b0, y0_reg};
    assign den     = {1'b0, rd_entry.x} - {1'b0, x0_reg};
    assign dx_mag  = dx[X_W]  ? X_W'(~dx + 1'b1)  : dx[X_W-1:0];
    assign dy_mag  = dy[Y_W]  ? Y_W'(~dy + 1'b1)  : dy[Y_W-1:0];
    assign den_mag = den[X_W] ? X_W'(~den + 1'b1) : den[X_W-1:0];

    assign div_shift = {rem_reg, acc_reg[PROD_W-1]};
    assign div_trial = div_shift - {1'b0, dvs_reg};
    assign div_ge    = div_shift >= {1'b0, dvs_reg};

    assign y0_ext = SUM_W'(y0_reg);
    assign q_ext  = SUM_W'(acc_reg);
    assign sum    = neg_reg ? (y0_ext - q_ext) : (y0_ext + q_ext);

    // Clamp the signed sum to the level range.
    always_comb begin
        if (sum[SUM_W-1]) begin
            level_sat = '0;
        end else if (|sum[SUM_W-2:Y_W]) begin
            level_sat = '1;
        end else begin
            level_sat = sum[Y_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and datapath.
    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        reading_next   = reading_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        hit_next       = hit_reg;
        seg_next       = seg_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_level_next   = m_level_reg;
        m_seg_next     = m_seg_reg;
        m_matched_next = m_matched_reg;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                // Entry zero is read while idle, so the scan starts with it.
                if (s_accept && (s_tuser == KIND_CONVERT)) begin
                    reading_next  = in_reading;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // rd_entry holds the entry at scan_idx_reg; fetch the next one.
                if (scan_idx_reg != LAST_IDX) begin
                    rd_addr = scan_idx_reg + 1'b1;
                end
                if (scan_idx_reg == '0) begin
                    x0_next       = rd_entry.x;
                    y0_next       = rd_entry.y;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end else if (reading_reg <= rd_entry.x) begin
                    hit_next = 1'b1;
                    seg_next = scan_idx_reg;
                    acc_next = '0;
                    if (den == '0) begin
                        // Flat segment: the level is y0.
                        neg_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        neg_next    = dx[X_W] ^ dy[Y_W] ^ den[X_W];
                        mcand_next  = PROD_W'(dy_mag);
                        mplier_next = dx_mag;
                        dvs_next    = den_mag;
                        cnt_next    = CNT_W'(X_W - 1);
                        state_next  = ST_MUL;
                    end
                end else if (scan_idx_reg == LAST_IDX) begin
                    // No breakpoint at or above the reading.
                    hit_next   = 1'b0;
                    seg_next   = '0;
                    y0_next    = '0;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    x0_next       = rd_entry.x;
                    y0_next       = rd_entry.y;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_MUL: begin
                // Shift-add, one multiplier bit per cycle, low bit first.
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(PROD_W - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                // Restoring division, one quotient bit per cycle. The
                // quotient shifts into the product register from below.
                if (div_ge) begin
                    rem_next = X_W'(div_trial);
                end else begin
                    rem_next = X_W'(div_shift);
                end
                acc_next = {acc_reg[PROD_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_level_next   = level_sat;
                    m_seg_next     = SEG_W'(seg_reg);
                    m_matched_next = hit_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        reading_reg   <= reading_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        hit_reg       <= hit_next;
        seg_reg       <= seg_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        m_level_reg   <= m_level_next;
        m_seg_reg     <= m_seg_next;
        m_matched_reg <= m_matched_next;
    end

    // Result channel.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_seg_reg, m_level_reg});
    assign m_tuser  = m_matched_reg;

endmodule

@@ design/plc_table.sv @@
// ---------------------------------------------------------------------------
// plc_table: breakpoint table of the calibration block
// One write port and one registered read port. A valid bit per entry makes
// entries that were never written read as their reset value.
// ---------------------------------------------------------------------------
module plc_table import plc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  plc_wr_t    wr,
    input  idx_t       rd_addr,
    output plc_entry_t rd_entry
);

    plc_entry_t               mem_reg [TABLE_ENTRIES];
    plc_entry_t               rd_data_reg;
    idx_t                     rd_addr_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;

    // Storage array with a registered read.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.idx] <= '{x: wr.x, y: wr.y};
        end
        rd_data_reg <= mem_reg[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written reads as x = 0 for entry zero, full scale
    // otherwise, and y = 0.
    always_comb begin
        if (rd_valid_reg) begin
            rd_entry = rd_data_reg;
        end else begin
            rd_entry.x = (rd_addr_reg == '0) ? '0 : X_MAX;
            rd_entry.y = '0;
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for piecewise_linear_calibration
// Loads breakpoint tables and converts readings over the request stream, with
// random gaps and stalls on both channels. A predictor tracks the table and
// computes the level, match flag and segment for every conversion accepted.
// Each result is checked against the oldest pending prediction.
// ---------------------------------------------------------------------------
module tb;
    import plc_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_TARGET   = 1350;

    // Predicted result of one conversion.
    typedef struct packed {
        logic             matched;
        logic [SEG_W-1:0] segment;
        y_t               level;
    } calib_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // entry_index[3:0], entry_x[15:4], entry_y[31:16], reading[43:32], zero
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // kind[0]
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // level[15:0], segment[19:16], zero
    logic [M_DATA_W-1:0] m_tdata;
    // matched[0]
    logic                m_tuser;

    // Predictor copy of the breakpoint table.
    x_t cal_x [TABLE_ENTRIES];
    y_t cal_y [TABLE_ENTRIES];

    calib_result_t pending_levels[$];
    int            mismatch_count = 0;
    int            items_sent     = 0;
    int            idle_cycles    = 0;
    bit            idling         = 1'b1;
    bit            hold_request   = 1'b0;

    piecewise_linear_calibration i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Search the table for the first breakpoint at or above the reading and
    // interpolate the segment below it, truncating toward zero.
    function automatic calib_result_t interpolate_level(input x_t rd);
        calib_result_t res;
        longint        r;
        longint        x0;
        longint        x1;
        longint        y0;
        longint        y1;
        longint        v;
        res = '0;
        r   = rd;
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (rd <= cal_x[i]) begin
                x0 = cal_x[i-1];
                x1 = cal_x[i];
                y0 = cal_y[i-1];
                y1 = cal_y[i];
                if (x1 == x0) begin
                    v = y0;
                end else begin
                    v = y0 + ((r - x0) * (y1 - y0)) / (x1 - x0);
                end
                if (v < 0) begin
                    v = 0;
                end
                if (v > 65535) begin
                    v = 65535;
                end
                res.level   = y_t'(v);
                res.matched = 1'b1;
                res.segment = i[SEG_W-1:0];
                return res;
            end
        end
        return res;
    endfunction

    // Offer one request, wait for it to be taken and update the prediction.
    // Valid stays high after acceptance so back-to-back requests never
    // lower and raise it in the same step.
    task automatic send_request(input logic kind, input idx_t idx, input x_t ex,
                                input y_t ey, input x_t rd);
        int gap;
        gap = idling ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_DATA_W-44){1'b0}}, rd, ey, ex, idx};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == KIND_WRITE) begin
            cal_x[idx] = ex;
            cal_y[idx] = ey;
        end else begin
            pending_levels.push_back(interpolate_level(rd));
        end
        items_sent++;
    endtask

    // A table write carries a random reading, which the block ignores.
    task automatic write_entry(input int idx, input int ex, input int ey);
        send_request(KIND_WRITE, idx_t'(idx), x_t'(ex), y_t'(ey),
                     x_t'($urandom_range(0, 4095)));
    endtask

    // A conversion carries random table fields, which the block ignores.
    task automatic convert(input int rd);
        send_request(KIND_CONVERT, idx_t'($urandom_range(0, 15)),
                     x_t'($urandom_range(0, 4095)), y_t'($urandom_range(0, 65535)),
                     x_t'(rd));
    endtask

    function automatic int rand_x();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int rand_y();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Readings aimed at breakpoints, the extremes and the unmatched range.
    function automatic int pick_reading();
        int r;
        int top;
        top = 0;
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (cal_x[i] > top) begin
                top = cal_x[i];
            end
        end
        case ($urandom_range(0, 9))
            0, 1, 2: r = int'(cal_x[$urandom_range(0, 15)]) + $urandom_range(0, 2) - 1;
            3:       r = $urandom_range(0, 1) ? 4095 : 0;
            4, 5:    r = $urandom_range(top, 4095);
            default: r = $urandom_range(0, 4095);
        endcase
        if (r < 0) begin
            r = 0;
        end
        if (r > 4095) begin
            r = 4095;
        end
        return r;
    endfunction

    // Load a full table with ascending breakpoints, sometimes with repeated
    // x values and sometimes ending below full scale.
    task automatic load_sorted_table();
        int xs[$];
        int ys[$];
        int top;
        top = $urandom_range(0, 1) ? 4095 : $urandom_range(16, 4094);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            xs.push_back($urandom_range(0, top));
            ys.push_back(rand_y());
        end
        xs.sort();
        if ($urandom_range(0, 1)) begin
            ys.sort();
        end
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                xs[i] = xs[i-1];
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            write_entry(i, xs[i], ys[i]);
        end
    endtask

    // Conversions against the table as it stands after reset.
    task automatic test_reset_table();
        convert(0);
        convert(4095);
        convert(2048);
    endtask

    // Full-scale breakpoints and levels.
    task automatic test_field_extremes();
        write_entry(0, 0, 0);
        write_entry(1, 4095, 65535);
        convert(0);
        convert(4095);
        convert(2048);
    endtask

    // A reading at two breakpoints with the same x returns the lower entry's level.
    task automatic test_flat_segment();
        write_entry(0, 0, 777);
        write_entry(1, 0, 500);
        convert(0);
        convert(1);
    endtask

    // Breakpoints out of order and readings below the lower breakpoint.
    task automatic test_unordered_table();
        write_entry(1, 2000, 100);
        write_entry(2, 1000, 60000);
        convert(1500);
        write_entry(0, 3000, 50000);
        convert(100);
    endtask

    // Interpolation results that overflow the level range on either side.
    task automatic test_saturation();
        write_entry(0, 100, 65535);
        write_entry(1, 200, 0);
        convert(0);
        write_entry(0, 100, 0);
        write_entry(1, 200, 65535);
        convert(0);
    endtask

    // Readings above every breakpoint find no segment; readings at and below the last one match.
    task automatic test_unmatched();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            write_entry(i, i * 100, i * 1000);
        end
        convert(1500);
        convert(1501);
        convert(4095);
        convert(1499);
    endtask

    // The receiver holds off for a long stretch while conversions keep
    // coming, so the result register fills and the input stalls.
    task automatic test_result_backpressure();
        idling       = 1'b0;
        hold_request = 1'b1;
        repeat (12) convert(pick_reading());
        idling = 1'b1;
    endtask

    // Mostly full tables followed by conversions, plus partial updates and
    // unstructured noise, until the item budget is used.
    task automatic test_random_tables();
        int mode;
        int n_conv;
        while (items_sent < ITEMS_TARGET) begin
            idling = ($urandom_range(0, 3) != 0);
            mode   = $urandom_range(0, 9);
            if (mode < 6) begin
                load_sorted_table();
                n_conv = $urandom_range(15, 40);
            end else if (mode < 8) begin
                repeat ($urandom_range(1, 4)) begin
                    write_entry($urandom_range(0, 15), rand_x(), rand_y());
                end
                n_conv = $urandom_range(5, 15);
            end else begin
                repeat ($urandom_range(5, 20)) begin
                    send_request(1'($urandom_range(0, 1)), idx_t'($urandom_range(0, 15)),
                                 x_t'(rand_x()), y_t'(rand_y()), x_t'(rand_x()));
                end
                n_conv = 0;
            end
            repeat (n_conv) convert(pick_reading());
        end
        idling = 1'b1;
    endtask

    // Result receiver: a random stall before each result, or one long
    // hold-off when a test asks for it.
    initial begin : result_receiver
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = idling ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid && !hold_request) @(posedge aclk);
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        calib_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual level %0d",
                         $realtime, m_tdata[15:0]);
                mismatch_count++;
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata[15:0] !== want.level) begin
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $realtime, want.level, m_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.matched) begin
                    $display("%0t: matched mismatch, expected %0d, actual %0d",
                             $realtime, want.matched, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[19:16] !== want.segment) begin
                    $display("%0t: segment mismatch, expected %0d, actual %0d",
                             $realtime, want.segment, m_tdata[19:16]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cal_x[i] = X_MAX;
            cal_y[i] = '0;
        end
        cal_x[0] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_table();
        test_field_extremes();
        test_flat_segment();
        test_unordered_table();
        test_saturation();
        test_unmatched();
        test_result_backpressure();
        test_random_tables();
        test_result_backpressure();

        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_levels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/plc_pkg.sv
design/plc_table.sv
design/piecewise_linear_calibration.sv
verif/tb.sv
